FILE: rtl/core/fft_magnitude_spectrum_defines.svh
// ----------------------------------------------------------------------------
// FFT magnitude spectrum assertion macros
// Shared property templates for the checks in the spectrum core.
// ----------------------------------------------------------------------------
`ifndef FFT_MAGNITUDE_SPECTRUM_DEFINES_SVH
`define FFT_MAGNITUDE_SPECTRUM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FMS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/fms_pkg.sv
// ----------------------------------------------------------------------------
// FFT magnitude spectrum package
// Word types, sizes, register indexes and the twiddle sine table.
// ----------------------------------------------------------------------------
package fms_pkg;

    localparam int WORD_W     = 24;
    localparam int TW_W       = 16;
    localparam int LMAX       = 6;
    localparam int MAX_POINTS = 64;
    localparam int QUARTER    = MAX_POINTS / 4;
    localparam int ADDR_W     = 6;
    localparam int MAG_W      = 15;
    localparam int SQ_W       = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [MAG_W-1:0]     MAG_LIMIT       = 15'h7FFF;
    localparam logic [CFG_IDX_W-1:0] REG_LOG2_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BINS_OUT    = 2'd1;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [TW_W-1:0]   twid_t;

    typedef struct packed {
        word_t im;
        word_t re;
    } cword_t;

    // Quarter wave of sin(2*pi*i/64) in Q1.15, rounded, top entry saturated.
    function automatic twid_t sine_quarter(input logic [4:0] idx);
        twid_t v;
        case (idx)
            5'd0:    v = 16'sd0;
            5'd1:    v = 16'sd3212;
            5'd2:    v = 16'sd6393;
            5'd3:    v = 16'sd9512;
            5'd4:    v = 16'sd12540;
            5'd5:    v = 16'sd15447;
            5'd6:    v = 16'sd18205;
            5'd7:    v = 16'sd20788;
            5'd8:    v = 16'sd23170;
            5'd9:    v = 16'sd25330;
            5'd10:   v = 16'sd27246;
            5'd11:   v = 16'sd28899;
            5'd12:   v = 16'sd30274;
            5'd13:   v = 16'sd31357;
            5'd14:   v = 16'sd32138;
            5'd15:   v = 16'sd32610;
            5'd16:   v = 16'sd32767;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    function automatic twid_t sine_at(input logic [ADDR_W-1:0] idx);
        logic [4:0] k;
        twid_t      v;
        k = idx[4:0];
        if (k > 5'd16)
        begin
            k = 5'd0 - k;
        end
        v = sine_quarter(k);
        return idx[ADDR_W-1] ? -v : v;
    endfunction

    function automatic word_t sat_word(input logic signed [WORD_W+2:0] v);
        word_t r;
        if (v > 27'sd8388607)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < -27'sd8388608)
        begin
            r = -24'sd8388608;
        end
        else
        begin
            r = WORD_W'(v);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/fms_butterfly.sv
// ----------------------------------------------------------------------------
// FFT butterfly unit
// Forms a+b and (a-b)*W with one shared multiplier over six steps.
// ----------------------------------------------------------------------------
module fms_butterfly
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  fms_pkg::cword_t in_a,
    input  fms_pkg::cword_t in_b,
    input  fms_pkg::twid_t  tw_re,
    input  fms_pkg::twid_t  tw_im,
    output logic            done,
    output fms_pkg::cword_t even,
    output fms_pkg::cword_t odd
);
    import fms_pkg::*;

    typedef enum logic [7:0] {
        BF_IDLE = 8'b0000_0001,
        BF_M0   = 8'b0000_0010,
        BF_M1   = 8'b0000_0100,
        BF_M2   = 8'b0000_1000,
        BF_M3   = 8'b0001_0000,
        BF_M4   = 8'b0010_0000,
        BF_M5   = 8'b0100_0000,
        BF_DONE = 8'b1000_0000
    } bf_state_t;

    bf_state_t                     state_reg, state_next;
    cword_t                        even_reg;
    word_t                         odd_re_reg, odd_im_reg;
    word_t                         dr_reg, di_reg;
    twid_t                         wr_reg, wi_reg;
    logic signed [WORD_W+TW_W-1:0] prod_reg;
    logic signed [WORD_W+TW_W:0]   acc_reg;
    word_t                         mul_x;
    twid_t                         mul_w;
    logic signed [WORD_W+TW_W-1:0] prod;
    logic signed [WORD_W+TW_W+1:0] rsum;
    word_t                         rounded;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BF_IDLE: if (start) state_next = BF_M0;
            BF_M0:   state_next = BF_M1;
            BF_M1:   state_next = BF_M2;
            BF_M2:   state_next = BF_M3;
            BF_M3:   state_next = BF_M4;
            BF_M4:   state_next = BF_M5;
            BF_M5:   state_next = BF_DONE;
            BF_DONE: state_next = BF_IDLE;
            default: state_next = BF_IDLE;
        endcase
    end

    always_comb
    begin
        mul_x = dr_reg;
        mul_w = wr_reg;
        case (state_reg)
            BF_M1:   begin mul_x = di_reg; mul_w = wi_reg; end
            BF_M2:   begin mul_x = dr_reg; mul_w = wi_reg; end
            BF_M3:   begin mul_x = di_reg; mul_w = wr_reg; end
            default: begin mul_x = dr_reg; mul_w = wr_reg; end
        endcase
        prod    = mul_x * mul_w;
        rsum    = (WORD_W+TW_W+2)'(acc_reg) + (WORD_W+TW_W+2)'(1 << (TW_W - 2));
        rounded = sat_word((WORD_W+3)'(rsum >>> (TW_W - 1)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BF_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BF_IDLE:
            begin
                if (start)
                begin
                    even_reg.re <= sat_word((WORD_W+3)'(in_a.re) + (WORD_W+3)'(in_b.re));
                    even_reg.im <= sat_word((WORD_W+3)'(in_a.im) + (WORD_W+3)'(in_b.im));
                    dr_reg      <= sat_word((WORD_W+3)'(in_a.re) - (WORD_W+3)'(in_b.re));
                    di_reg      <= sat_word((WORD_W+3)'(in_a.im) - (WORD_W+3)'(in_b.im));
                    wr_reg      <= tw_re;
                    wi_reg      <= tw_im;
                end
            end
            BF_M0:
            begin
                prod_reg <= prod;
            end
            BF_M1:
            begin
                acc_reg  <= (WORD_W+TW_W+1)'(prod_reg);
                prod_reg <= prod;
            end
            BF_M2:
            begin
                acc_reg  <= acc_reg - (WORD_W+TW_W+1)'(prod_reg);
                prod_reg <= prod;
            end
            BF_M3:
            begin
                odd_re_reg <= rounded;
                acc_reg    <= (WORD_W+TW_W+1)'(prod_reg);
                prod_reg   <= prod;
            end
            BF_M4:
            begin
                acc_reg <= acc_reg + (WORD_W+TW_W+1)'(prod_reg);
            end
            BF_M5:
            begin
                odd_im_reg <= rounded;
            end
            default:
            begin
            end
        endcase
    end

    assign done   = (state_reg == BF_DONE);
    assign even   = even_reg;
    assign odd.re = odd_re_reg;
    assign odd.im = odd_im_reg;

endmodule

FILE: rtl/core/fms_magnitude.sv
// ----------------------------------------------------------------------------
// FFT bin magnitude unit
// Squares and sums one bin with a shared multiplier, then takes the floor
// square root two radicand bits per cycle and saturates it.
// ----------------------------------------------------------------------------
module fms_magnitude
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  fms_pkg::cword_t          bin,
    output logic                     done,
    output logic [fms_pkg::MAG_W-1:0] magnitude
);
    import fms_pkg::*;

    typedef enum logic [5:0] {
        SQ_IDLE = 6'b00_0001,
        SQ_RE   = 6'b00_0010,
        SQ_IM   = 6'b00_0100,
        SQ_SUM  = 6'b00_1000,
        SQ_ITER = 6'b01_0000,
        SQ_DONE = 6'b10_0000
    } sq_state_t;

    localparam int ITER_N = SQ_W / 2;

    sq_state_t                  state_reg, state_next;
    word_t                      re_reg, im_reg;
    logic signed [SQ_W-1:0]     prod_reg;
    logic [SQ_W-1:0]            acc_reg;
    logic [SQ_W-1:0]            x_reg;
    logic [SQ_W-1:0]            r_reg;
    logic [SQ_W-1:0]            bit_reg;
    logic [$clog2(ITER_N)-1:0]  cnt_reg;
    word_t                      mul_x;
    logic signed [SQ_W-1:0]     prod;
    logic [SQ_W-1:0]            trial;

    always_comb
    begin
        mul_x = (state_reg == SQ_IM) ? im_reg : re_reg;
        prod  = mul_x * mul_x;
        trial = r_reg + bit_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SQ_IDLE: if (start) state_next = SQ_RE;
            SQ_RE:   state_next = SQ_IM;
            SQ_IM:   state_next = SQ_SUM;
            SQ_SUM:  state_next = SQ_ITER;
            SQ_ITER:
            begin
                if (cnt_reg == ($clog2(ITER_N))'(ITER_N - 1))
                begin
                    state_next = SQ_DONE;
                end
            end
            SQ_DONE: if (start) state_next = SQ_RE;
            default: state_next = SQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            SQ_RE:
            begin
                prod_reg <= prod;
            end
            SQ_IM:
            begin
                acc_reg  <= $unsigned(prod_reg);
                prod_reg <= prod;
            end
            SQ_SUM:
            begin
                x_reg   <= acc_reg + $unsigned(prod_reg);
                r_reg   <= '0;
                bit_reg <= SQ_W'(1) << (SQ_W - 2);
                cnt_reg <= '0;
            end
            SQ_ITER:
            begin
                if (x_reg >= trial)
                begin
                    x_reg <= x_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
        if (start && (state_reg == SQ_IDLE || state_reg == SQ_DONE))
        begin
            re_reg <= bin.re;
            im_reg <= bin.im;
        end
    end

    assign done      = (state_reg == SQ_DONE);
    assign magnitude = (r_reg > SQ_W'(MAG_LIMIT)) ? MAG_LIMIT : r_reg[MAG_W-1:0];

endmodule

FILE: rtl/core/fft_magnitude_spectrum.sv
// ----------------------------------------------------------------------------
// FFT magnitude spectrum
// Collects 2^L complex samples, runs a radix-2 Stockham FFT with one shared
// butterfly unit and emits the saturated magnitudes of the leading bins.
// ----------------------------------------------------------------------------
// Loading takes one sample item per cycle while the core is idle.
// The transform runs L * 2^(L-1) butterflies one at a time through
// the single butterfly unit and its one multiplier.
// Emitted bins then pass one at a time through the square root unit.
// Reset clears the fill count and sets log2_length to 6 and bins_out to 32.
`include "fft_magnitude_spectrum_defines.svh"

module fft_magnitude_spectrum
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample_real, sample_imag
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // bin_index, magnitude
    output logic [23:0]                         m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fms_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fms_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import fms_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_FFT_RD   = 8'b0000_0010,
        ST_FFT_GO   = 8'b0000_0100,
        ST_FFT_WAIT = 8'b0000_1000,
        ST_FFT_WO   = 8'b0001_0000,
        ST_MAG_RD   = 8'b0010_0000,
        ST_MAG_GO   = 8'b0100_0000,
        ST_MAG_WAIT = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [2:0]             log2_reg, log2_next;
    logic [6:0]             bins_reg, bins_next;
    logic [6:0]             load_count_reg, load_count_next;
    logic [2:0]             l_reg, l_next;
    logic [6:0]             k_reg, k_next;
    logic [2:0]             t_reg, t_next;
    logic [ADDR_W-2:0]      j_reg, j_next;
    logic                   src_reg, src_next;
    logic [ADDR_W-1:0]      bin_reg, bin_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]      out_bin_reg;
    logic [MAG_W-1:0]       out_mag_reg;
    logic                   out_last_reg;

    cword_t                 mem0 [MAX_POINTS];
    cword_t                 mem1 [MAX_POINTS];
    cword_t                 rd0a_reg, rd0b_reg, rd1a_reg, rd1b_reg;
    logic [ADDR_W-1:0]      rd_addr_a, rd_addr_b;
    logic                   we0, we1;
    logic [ADDR_W-1:0]      wa0, wa1;
    cword_t                 wd0, wd1;

    logic [2:0]             l_eff;
    logic [6:0]             n_eff;
    logic [6:0]             load_inc;
    logic                   load_we;
    cword_t                 sample;
    logic [ADDR_W-1:0]      j_ext, p_ext, half, e_addr, o_addr, tw_idx, s_mask;
    logic [ADDR_W-2:0]      half_m1;
    logic [2:0]             tw_sh;
    logic                   fft_we;
    cword_t                 src_a, src_b;
    twid_t                  tw_re, tw_im;
    logic                   bf_start, bf_done;
    cword_t                 bf_even, bf_odd;
    logic                   mag_start, mag_done;
    logic [MAG_W-1:0]       mag_value;
    logic                   last_now;
    logic                   out_load;

    fms_butterfly u_butterfly
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bf_start),
        .in_a  (src_a),
        .in_b  (src_b),
        .tw_re (tw_re),
        .tw_im (tw_im),
        .done  (bf_done),
        .even  (bf_even),
        .odd   (bf_odd)
    );

    fms_magnitude u_magnitude
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mag_start),
        .bin       (src_a),
        .done      (mag_done),
        .magnitude (mag_value)
    );

    always_comb
    begin
        if (log2_reg == 3'd0)
        begin
            l_eff = 3'd1;
        end
        else if (log2_reg > 3'(LMAX))
        begin
            l_eff = 3'(LMAX);
        end
        else
        begin
            l_eff = log2_reg;
        end
        n_eff     = 7'd1 << l_eff;
        load_inc  = load_count_reg + 7'd1;
        sample.re = WORD_W'($signed(s_tdata[SAMPLE_BITS-1:0]));
        sample.im = WORD_W'($signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));

        j_ext   = {1'b0, j_reg};
        half    = ADDR_W'(1) << (l_reg - 3'd1);
        half_m1 = (ADDR_W-1)'(half - ADDR_W'(1));
        s_mask  = (ADDR_W'(1) << t_reg) - ADDR_W'(1);
        p_ext   = j_ext >> t_reg;
        e_addr  = (p_ext << (t_reg + 3'd1)) | (j_ext & s_mask);
        o_addr  = e_addr | (ADDR_W'(1) << t_reg);
        tw_sh   = 3'(LMAX) - l_reg + t_reg;
        tw_idx  = p_ext << tw_sh;
        tw_re   = sine_at(tw_idx + ADDR_W'(QUARTER));
        tw_im   = -sine_at(tw_idx);

        src_a = src_reg ? rd1a_reg : rd0a_reg;
        src_b = src_reg ? rd1b_reg : rd0b_reg;
    end

    always_comb
    begin
        load_we   = (state_reg == ST_IDLE) && s_tvalid;
        fft_we    = (state_reg == ST_FFT_WAIT && bf_done) || (state_reg == ST_FFT_WO);
        bf_start  = (state_reg == ST_FFT_GO);
        mag_start = (state_reg == ST_MAG_GO);
        last_now  = ({1'b0, bin_reg} == (k_reg - 7'd1));
        out_load  = (state_reg == ST_MAG_WAIT) && mag_done && (!out_valid_reg || m_tready);

        rd_addr_a = (state_reg == ST_MAG_RD) ? bin_reg : j_ext;
        rd_addr_b = j_ext + half;

        we0 = load_we || (fft_we && src_reg);
        we1 = fft_we && !src_reg;
        wa0 = load_we ? load_count_reg[ADDR_W-1:0]
                      : ((state_reg == ST_FFT_WO) ? o_addr : e_addr);
        wa1 = (state_reg == ST_FFT_WO) ? o_addr : e_addr;
        wd0 = load_we ? sample : ((state_reg == ST_FFT_WO) ? bf_odd : bf_even);
        wd1 = (state_reg == ST_FFT_WO) ? bf_odd : bf_even;
    end

    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            mem0[wa0] <= wd0;
        end
        rd0a_reg <= mem0[rd_addr_a];
        rd0b_reg <= mem0[rd_addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            mem1[wa1] <= wd1;
        end
        rd1a_reg <= mem1[rd_addr_a];
        rd1b_reg <= mem1[rd_addr_b];
    end

    always_comb
    begin
        state_next      = state_reg;
        log2_next       = log2_reg;
        bins_next       = bins_reg;
        load_count_next = load_count_reg;
        l_next          = l_reg;
        k_next          = k_reg;
        t_next          = t_reg;
        j_next          = j_reg;
        src_next        = src_reg;
        bin_next        = bin_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LOG2_LENGTH: log2_next = cfg_data[2:0];
                REG_BINS_OUT:    bins_next = cfg_data;
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (load_inc >= n_eff)
                    begin
                        load_count_next = '0;
                        l_next          = l_eff;
                        k_next          = (bins_reg > n_eff) ? n_eff : bins_reg;
                        t_next          = '0;
                        j_next          = '0;
                        src_next        = 1'b0;
                        state_next      = ST_FFT_RD;
                    end
                    else
                    begin
                        load_count_next = load_inc;
                    end
                end
            end
            ST_FFT_RD:
            begin
                state_next = ST_FFT_GO;
            end
            ST_FFT_GO:
            begin
                state_next = ST_FFT_WAIT;
            end
            ST_FFT_WAIT:
            begin
                if (bf_done)
                begin
                    state_next = ST_FFT_WO;
                end
            end
            ST_FFT_WO:
            begin
                if (j_reg == half_m1)
                begin
                    j_next   = '0;
                    src_next = !src_reg;
                    if (t_reg == l_reg - 3'd1)
                    begin
                        bin_next   = '0;
                        state_next = (k_reg == 7'd0) ? ST_IDLE : ST_MAG_RD;
                    end
                    else
                    begin
                        t_next     = t_reg + 3'd1;
                        state_next = ST_FFT_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_FFT_RD;
                end
            end
            ST_MAG_RD:
            begin
                state_next = ST_MAG_GO;
            end
            ST_MAG_GO:
            begin
                state_next = ST_MAG_WAIT;
            end
            ST_MAG_WAIT:
            begin
                if (out_load)
                begin
                    if (last_now)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        bin_next   = bin_reg + 1'b1;
                        state_next = ST_MAG_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            log2_reg       <= 3'd6;
            bins_reg       <= 7'd32;
            load_count_reg <= '0;
            l_reg          <= 3'd1;
            k_reg          <= '0;
            t_reg          <= '0;
            j_reg          <= '0;
            src_reg        <= 1'b0;
            bin_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            log2_reg       <= log2_next;
            bins_reg       <= bins_next;
            load_count_reg <= load_count_next;
            l_reg          <= l_next;
            k_reg          <= k_next;
            t_reg          <= t_next;
            j_reg          <= j_next;
            src_reg        <= src_next;
            bin_reg        <= bin_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_bin_reg  <= bin_reg;
            out_mag_reg  <= mag_value;
            out_last_reg <= last_now;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b000, out_mag_reg, out_bin_reg};
    assign m_tlast   = out_last_reg;

    `FMS_ASSERT_IMP(a_bf_done_in_wait, clk, rst_n, bf_done, state_reg == ST_FFT_WAIT, "butterfly finished outside its wait state")
    `FMS_ASSERT_IMP(a_mag_rose_in_wait, clk, rst_n, $rose(mag_done), state_reg == ST_MAG_WAIT, "magnitude finished outside its wait state")
    `FMS_ASSERT_IMP(a_stage_in_range, clk, rst_n, state_reg == ST_FFT_WO, t_reg < l_reg, "stage counter beyond transform length")
    `FMS_ASSERT_NXT(a_last_returns_idle, clk, rst_n, out_load && last_now, state_reg == ST_IDLE, "final bin did not return to idle")

endmodule

FILE: dv/fft_magnitude_spectrum_test.sv
// ----------------------------------------------------------------------------
// FFT magnitude spectrum testbench
// Streams complex samples into the spectrum core under several transform
// lengths and bin counts, predicts every emitted magnitude bin with an
// independent fixed-point Stockham FFT, and checks each bin as it leaves.
// ----------------------------------------------------------------------------
module fft_magnitude_spectrum_test;

    import fms_pkg::*;

    typedef struct {
        logic [5:0]  bin;
        logic [14:0] mag;
        logic        last;
    } bin_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [31:0] samples_pending[$];
    bin_item_t   bins_expected[$];

    longint      spec_re[64];
    longint      spec_im[64];
    longint      scratch_re[64];
    longint      scratch_im[64];
    longint      sine_table[17];
    int          fill_count;
    int          length_exp;
    int          bins_wanted;
    int          errors;
    int          accepted;
    int          cycles;

    fft_magnitude_spectrum dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic longint quarter_sine(longint unsigned k);
        longint unsigned pi_q60;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        pi_q60 = 64'h3243F6A8885A308D;
        x = ((pi_q60 / 64) * 2 * k) >> 30;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int j = 1; j <= 12; j++)
        begin
            term = ((term * x2) >> 30) / ((2 * j) * (2 * j + 1));
            if (j % 2 == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > (64'sd1 << 30))
        begin
            sum = 64'sd1 << 30;
        end
        sum = (sum + (64'sd1 << 14)) >>> 15;
        if (sum > 32767)
        begin
            sum = 32767;
        end
        return sum;
    endfunction

    function automatic longint twiddle_sine(int idx);
        bit neg;
        idx = idx & 63;
        neg = idx >= 32;
        if (neg)
        begin
            idx = idx - 32;
        end
        if (idx > 16)
        begin
            idx = 32 - idx;
        end
        return neg ? -sine_table[idx] : sine_table[idx];
    endfunction

    function automatic longint clip24(longint v);
        if (v > 8388607)
        begin
            return 8388607;
        end
        if (v < -8388608)
        begin
            return -8388608;
        end
        return v;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic spectrum_take_sample(logic [31:0] item);
        int        lg;
        int        n;
        int        span;
        int        s;
        int        m;
        int        stride;
        int        ia;
        int        ib;
        int        ie;
        int        io;
        int        k;
        longint    wr;
        longint    wi;
        longint    dr;
        longint    di;
        longint    ar;
        longint    ai;
        longint    br;
        longint    bi;
        bin_item_t e;
        lg = length_exp;
        if (lg < 1)
        begin
            lg = 1;
        end
        if (lg > LMAX)
        begin
            lg = LMAX;
        end
        n = 1 << lg;
        spec_re[fill_count & 63] = longint'($signed(item[15:0]));
        spec_im[fill_count & 63] = longint'($signed(item[31:16]));
        fill_count++;
        if (fill_count < n)
        begin
            return;
        end
        fill_count = 0;
        span = n;
        s = 1;
        while (span > 1)
        begin
            m = span / 2;
            stride = 64 / span;
            for (int p = 0; p < m; p++)
            begin
                wr = twiddle_sine(p * stride + 16);
                wi = -twiddle_sine(p * stride);
                for (int q = 0; q < s; q++)
                begin
                    ia = q + s * p;
                    ib = q + s * (p + m);
                    ar = spec_re[ia];
                    ai = spec_im[ia];
                    br = spec_re[ib];
                    bi = spec_im[ib];
                    dr = clip24(ar - br);
                    di = clip24(ai - bi);
                    ie = q + s * (2 * p);
                    io = q + s * (2 * p + 1);
                    scratch_re[ie] = clip24(ar + br);
                    scratch_im[ie] = clip24(ai + bi);
                    scratch_re[io] = clip24((dr * wr - di * wi + 16384) >>> 15);
                    scratch_im[io] = clip24((dr * wi + di * wr + 16384) >>> 15);
                end
            end
            for (int i = 0; i < n; i++)
            begin
                spec_re[i] = scratch_re[i];
                spec_im[i] = scratch_im[i];
            end
            span = m;
            s = s * 2;
        end
        k = bins_wanted > n ? n : bins_wanted;
        for (int i = 0; i < k; i++)
        begin
            e.bin = i[5:0];
            e.mag = 15'h7FFF;
            if (floor_sqrt(longint'(spec_re[i] * spec_re[i] + spec_im[i] * spec_im[i]))
                < 64'd32767)
            begin
                e.mag = 15'(floor_sqrt(spec_re[i] * spec_re[i] + spec_im[i] * spec_im[i]));
            end
            e.last = (i + 1 == k);
            bins_expected.push_back(e);
        end
    endtask

    function automatic int idle_percent(bit receiver);
        if (accepted < 70)
        begin
            return receiver ? 55 : 33;
        end
        if (accepted < 140)
        begin
            return receiver ? 33 : 55;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                spectrum_take_sample(s_tdata);
                accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (samples_pending.size() != 0
                    && $urandom_range(99, 0) >= idle_percent(1'b0))
                begin
                    s_tdata  <= samples_pending.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        bin_item_t e;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (bins_expected.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected bin, actual bin %0d mag %0d last %0b",
                             $time, m_tdata[5:0], m_tdata[20:6], m_tlast);
                end
                else
                begin
                    e = bins_expected.pop_front();
                    if (m_tdata[5:0] !== e.bin || m_tdata[20:6] !== e.mag
                        || m_tdata[23:21] !== 3'b000 || m_tlast !== e.last)
                    begin
                        errors++;
                        $display("%0t: mismatch, expected bin %0d mag %0d last %0b, actual bin %0d mag %0d last %0b pad %0h",
                                 $time, e.bin, e.mag, e.last,
                                 m_tdata[5:0], m_tdata[20:6], m_tlast, m_tdata[23:21]);
                    end
                end
            end
            m_tready <= $urandom_range(99, 0) >= idle_percent(1'b1);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 1500000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [15:0] pick_part();
        case ($urandom_range(5, 0))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'(int'($urandom_range(64, 0)) - 32);
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_samples(int count);
        for (int i = 0; i < count; i++)
        begin
            samples_pending.push_back({pick_part(), pick_part()});
        end
    endtask

    task automatic wait_quiet();
        do
        begin
            @(posedge clk);
        end
        while (samples_pending.size() != 0 || s_tvalid || bins_expected.size() != 0);
        repeat (bins_wanted == 0 ? 6000 : 20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_LOG2_LENGTH)
        begin
            length_exp = value & 7;
        end
        else if (idx == REG_BINS_OUT)
        begin
            bins_wanted = value & 127;
        end
        @(posedge clk);
    endtask

    initial
    begin
        int lg;
        int n;
        errors      = 0;
        accepted    = 0;
        cycles      = 0;
        fill_count  = 0;
        length_exp  = 6;
        bins_wanted = 32;
        for (int k = 0; k <= 16; k++)
        begin
            sine_table[k] = quarter_sine(k);
        end
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_LOG2_LENGTH, 3);
        write_reg(REG_BINS_OUT, 8);
        for (int i = 0; i < 8; i++)
        begin
            samples_pending.push_back({16'h8000, 16'h7FFF});
        end
        wait_quiet();
        write_reg(REG_LOG2_LENGTH, 1);
        write_reg(REG_BINS_OUT, 64);
        samples_pending.push_back({16'h8000, 16'h8000});
        samples_pending.push_back({16'h7FFF, 16'h7FFF});
        wait_quiet();
        write_reg(REG_LOG2_LENGTH, 0);
        queue_samples(2);
        wait_quiet();
        write_reg(REG_LOG2_LENGTH, 2);
        write_reg(REG_BINS_OUT, 0);
        queue_samples(4);
        wait_quiet();
        write_reg(2'd2, 5);
        write_reg(REG_LOG2_LENGTH, 3);
        write_reg(REG_BINS_OUT, 127);
        queue_samples(3);
        wait_quiet();
        write_reg(REG_LOG2_LENGTH, 1);
        queue_samples(1);
        wait_quiet();

        write_reg(REG_LOG2_LENGTH, 7);
        write_reg(REG_BINS_OUT, 64);
        queue_samples(64);
        wait_quiet();
        while (accepted < 165)
        begin
            lg = ($urandom_range(5, 0) == 0) ? int'($urandom_range(7, 5))
                                             : int'($urandom_range(4, 0));
            write_reg(REG_LOG2_LENGTH, lg);
            if ($urandom_range(3, 0) == 0)
            begin
                write_reg(2'd3, $urandom_range(127, 0));
            end
            write_reg(REG_BINS_OUT, ($urandom_range(4, 0) == 0) ? 0
                                    : int'($urandom_range(127, 1)));
            n = 1 << ((lg < 1) ? 1 : (lg > LMAX ? LMAX : lg));
            queue_samples(n * int'($urandom_range(3, 1))
                          + (($urandom_range(3, 0) == 0) ? int'($urandom_range(3, 1)) : 0));
            wait_quiet();
        end
        wait_quiet();
        repeat (6000) @(posedge clk);
        if (errors == 0 && bins_expected.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/fms_pkg.sv
rtl/core/fms_butterfly.sv
rtl/core/fms_magnitude.sv
rtl/core/fft_magnitude_spectrum.sv
dv/fft_magnitude_spectrum_test.sv
